### rtl/pcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 18;
  localparam int ATAN_LEN     = 31;
  localparam int NSTEP        = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  localparam int DW = 32;
  localparam int XW = 34;
  localparam int ZW = 34;
  localparam int WW = 64 - FRAC_BITS;
  localparam int WH = WW - 24;
  localparam int PW = DW + XW;
  localparam int SW = WW + XW + 2;

  localparam logic [31:0] INV_TWO_PI_HI = 32'h28BE60DB;
  localparam logic [31:0] INV_TWO_PI_LO = 32'h9391054A;
  localparam int          GAIN_Q30      = 652032874;

  localparam logic [31:0] ATAN_PHASE [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001
  };

  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    logic                 flip;
    logic signed [DW-1:0] r;
    logic signed [DW-1:0] dr;
    logic signed [WW-1:0] w;
  } pcs_side_t;

endpackage
`default_nettype wire

### rtl/pcs_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pcs_in_if;
  import pcs_pkg::*;
  logic  valid;
  logic  ready;
  word_t radius;
  word_t angle;
  word_t radial_rate;
  word_t angular_rate;
  modport source (output valid, radius, angle, radial_rate, angular_rate, input ready);
  modport sink (input valid, radius, angle, radial_rate, angular_rate, output ready);
endinterface

interface pcs_out_if;
  import pcs_pkg::*;
  logic  valid;
  logic  ready;
  word_t pos_x;
  word_t pos_y;
  word_t vel_x;
  word_t vel_y;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface
`default_nettype wire

### rtl/pcs_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module pcs_cordic (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          en,
  input  wire                          valid_in,
  input  wire signed [pcs_pkg::ZW-1:0] z_in,
  input  wire pcs_pkg::pcs_side_t      side_in,
  output logic                         valid_out,
  output logic signed [pcs_pkg::XW-1:0] x_out,
  output logic signed [pcs_pkg::XW-1:0] y_out,
  output pcs_pkg::pcs_side_t           side_out
);
  import pcs_pkg::*;

  logic                 vs [0:NSTEP];
  logic signed [XW-1:0] xs [0:NSTEP];
  logic signed [XW-1:0] ys [0:NSTEP];
  logic signed [ZW-1:0] zs [0:NSTEP];
  pcs_side_t            sd [0:NSTEP];

  assign vs[0] = valid_in;
  assign xs[0] = XW'(GAIN_Q30);
  assign ys[0] = '0;
  assign zs[0] = z_in;
  assign sd[0] = side_in;

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_PHASE[i]);
    logic signed [XW-1:0] xsh;
    logic signed [XW-1:0] ysh;
    assign xsh = xs[i] >>> i;
    assign ysh = ys[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[i+1] <= sd[i];
        if (!zs[i][ZW-1]) begin
          xs[i+1] <= xs[i] - ysh;
          ys[i+1] <= ys[i] + xsh;
          zs[i+1] <= zs[i] - ANG;
        end else begin
          xs[i+1] <= xs[i] + ysh;
          ys[i+1] <= ys[i] - xsh;
          zs[i+1] <= zs[i] + ANG;
        end
      end
    end
  end

  assign valid_out = vs[NSTEP];
  assign x_out     = xs[NSTEP];
  assign y_out     = ys[NSTEP];
  assign side_out  = sd[NSTEP];

endmodule
`default_nettype wire

### rtl/polar_to_cartesian_state.sv
`timescale 1ns / 1ps
`default_nettype none
// Polar to Cartesian state conversion.
// rows (sink): radius, angle, radial_rate, angular_rate, signed Q16.16, angle
//   in radians of any size. states (source): pos_x, pos_y, vel_x, vel_y,
//   signed Q16.16, saturated. One transaction out for each transaction in.
// Stages, in order: phase multiply, phase round and fold, one CORDIC step
//   per stage, quadrant fix, partial products, product merge, round and
//   saturate into the output register.
// Throughput: one transaction per cycle while results are taken; the stages
//   are fully pipelined and rows are independent.
// The whole pipeline advances while the output register is empty or taken.
//   When the receiver stalls with a result waiting, every stage holds and
//   rows.ready drops; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; no row is kept.
module polar_to_cartesian_state (
  input wire clk,
  input wire rst,
  pcs_in_if.sink    rows,
  pcs_out_if.source states
);
  import pcs_pkg::*;

  function automatic word_t sat_round(input logic signed [SW-1:0] a);
    logic signed [SW-1:0] q;
    q = (a + (SW'(1) <<< 29)) >>> 30;
    if (!q[SW-1] && (q[SW-2:DW-1] != '0)) begin
      sat_round = {1'b0, {(DW-1){1'b1}}};
    end else if (q[SW-1] && (q[SW-2:DW-1] != '1)) begin
      sat_round = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat_round = q[DW-1:0];
    end
  endfunction

  logic en;
  assign en = !states.valid || states.ready;
  assign rows.ready = en;

  // stage 1: phase products and r * dtheta
  logic                 v1;
  logic                 neg1;
  logic [63:0]          plo1;
  logic [63:0]          phi1;
  logic signed [63:0]   rw1;
  word_t                r1;
  word_t                dr1;
  logic [31:0]          mag;

  assign mag = rows.angle[DW-1] ? (~rows.angle + 32'd1) : rows.angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= rows.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= rows.angle[DW-1];
      plo1 <= 64'(mag) * 64'(INV_TWO_PI_LO);
      phi1 <= 64'(mag) * 64'(INV_TWO_PI_HI);
      rw1  <= 64'(rows.radius) * 64'(rows.angular_rate);
      r1   <= rows.radius;
      dr1  <= rows.radial_rate;
    end
  end

  // stage 2: phase round, sign, fold; w round
  logic                 v2;
  logic signed [ZW-1:0] z2;
  pcs_side_t            side2;
  logic [63:0]          usum;
  logic [31:0]          ph_abs;
  logic [31:0]          ph_sgn;
  logic                 flip;
  logic [31:0]          ph_fold;
  logic signed [64:0]   wsum;

  always_comb begin
    usum    = phi1 + {32'b0, plo1[63:32]} + (64'd1 << (FRAC_BITS - 1));
    ph_abs  = usum[FRAC_BITS+31:FRAC_BITS];
    ph_sgn  = neg1 ? (32'd0 - ph_abs) : ph_abs;
    flip    = (ph_sgn[31:30] == 2'b01) || (ph_sgn[31:30] == 2'b10);
    ph_fold = flip ? {~ph_sgn[31], ph_sgn[30:0]} : ph_sgn;
    wsum    = (65'(rw1) + (65'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z2         <= ZW'($signed(ph_fold));
      side2.flip <= flip;
      side2.r    <= r1;
      side2.dr   <= dr1;
      side2.w    <= wsum[WW-1:0];
    end
  end

  // CORDIC pipeline
  logic                 vc;
  logic signed [XW-1:0] xc;
  logic signed [XW-1:0] yc;
  pcs_side_t            sidec;

  pcs_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (v2),
    .z_in      (z2),
    .side_in   (side2),
    .valid_out (vc),
    .x_out     (xc),
    .y_out     (yc),
    .side_out  (sidec)
  );

  // quadrant fix
  logic                 vf;
  logic signed [XW-1:0] xf;
  logic signed [XW-1:0] yf;
  pcs_side_t            sidef;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xf    <= sidec.flip ? -xc : xc;
      yf    <= sidec.flip ? -yc : yc;
      sidef <= sidec;
    end
  end

  // partial products
  logic                    vm1;
  logic signed [PW-1:0]    rx;
  logic signed [PW-1:0]    ry;
  logic signed [PW-1:0]    dx;
  logic signed [PW-1:0]    dy;
  logic signed [WH+XW-1:0] why;
  logic signed [WH+XW-1:0] whx;
  logic signed [XW+24:0]   wly;
  logic signed [XW+24:0]   wlx;
  logic signed [WH-1:0]    wh;
  logic signed [24:0]      wl;

  assign wh = sidef.w[WW-1:24];
  assign wl = $signed({1'b0, sidef.w[23:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
    end else if (en) begin
      vm1 <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx  <= PW'(sidef.r) * PW'(xf);
      ry  <= PW'(sidef.r) * PW'(yf);
      dx  <= PW'(sidef.dr) * PW'(xf);
      dy  <= PW'(sidef.dr) * PW'(yf);
      why <= (WH+XW)'(wh) * (WH+XW)'(yf);
      whx <= (WH+XW)'(wh) * (WH+XW)'(xf);
      wly <= (XW+25)'(wl) * (XW+25)'(yf);
      wlx <= (XW+25)'(wl) * (XW+25)'(xf);
    end
  end

  // merge w products
  logic                 vm2;
  logic signed [SW-1:0] rx2;
  logic signed [SW-1:0] ry2;
  logic signed [SW-1:0] dx2;
  logic signed [SW-1:0] dy2;
  logic signed [SW-1:0] wy2;
  logic signed [SW-1:0] wx2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm2 <= 1'b0;
    end else if (en) begin
      vm2 <= vm1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx2 <= SW'(rx);
      ry2 <= SW'(ry);
      dx2 <= SW'(dx);
      dy2 <= SW'(dy);
      wy2 <= (SW'(why) <<< 24) + SW'(wly);
      wx2 <= (SW'(whx) <<< 24) + SW'(wlx);
    end
  end

  // round, saturate, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      states.valid <= 1'b0;
    end else if (en) begin
      states.valid <= vm2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      states.pos_x <= sat_round(rx2);
      states.pos_y <= sat_round(ry2);
      states.vel_x <= sat_round(dx2 - wy2);
      states.vel_y <= sat_round(dy2 + wx2);
    end
  end

endmodule
`default_nettype wire

### tb/pcs_tb_if.sv
`timescale 1ns / 1ps
// The block's channel interfaces (pcs_in_if, pcs_out_if) come with the RTL.
// The bench adds no interface of its own; this file only carries the
// row and result structs that the bench shares.
package pcs_tb_pkg;
  import pcs_pkg::*;

  typedef struct packed {
    word_t radius;
    word_t angle;
    word_t radial_rate;
    word_t angular_rate;
  } row_t;

  typedef struct packed {
    word_t pos_x;
    word_t pos_y;
    word_t vel_x;
    word_t vel_y;
  } cart_t;
endpackage

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import pcs_pkg::*;
  import pcs_tb_pkg::*;

  localparam int LATENCY = CORDIC_STEPS + 6;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  pcs_in_if  rows ();
  pcs_out_if states ();

  polar_to_cartesian_state dut (.clk(clk), .rst(rst), .rows(rows.sink), .states(states.source));

  cart_t  cart_q [$];
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_off = 0;
  int     errors = 0;
  int     rows_sent = 0;
  int     states_seen = 0;
  longint cycles = 0;

  function automatic logic signed [63:0] fshr(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  // round-half-up((a1*b1 + a2*b2) / 2^30) with saturation
  function automatic word_t fuse_sat(logic signed [63:0] a1, logic signed [63:0] b1,
                                     logic signed [63:0] a2, logic signed [63:0] b2);
    logic signed [127:0] acc;
    acc = 128'(a1) * 128'(b1) + 128'(a2) * 128'(b2) + (128'sd1 <<< 29);
    acc = acc >>> 30;
    if (acc > 128'sd2147483647) return 32'h7FFFFFFF;
    if (acc < -128'sd2147483648) return 32'h80000000;
    return acc[31:0];
  endfunction

  function automatic cart_t convert_row(row_t rw);
    cart_t c;
    logic signed [63:0] r, th, dr, dth, x, y, z, xs, ys, w;
    logic [63:0] mag;
    logic [127:0] um;
    logic [31:0] phase;
    logic neg, flip;
    r = rw.radius; th = rw.angle; dr = rw.radial_rate; dth = rw.angular_rate;
    neg = th < 0;
    mag = neg ? 64'(-th) : 64'(th);
    um = 128'(mag) * 128'({INV_TWO_PI_HI, INV_TWO_PI_LO});
    um = um >> 32;
    um = (um + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    phase = um[31:0];
    if (neg) phase = -phase;
    flip = phase[31:30] == 2'd1 || phase[31:30] == 2'd2;
    if (flip) phase = phase - 32'h80000000;
    z = 64'(signed'(phase));
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < NSTEP; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - 64'(ATAN_PHASE[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + 64'(ATAN_PHASE[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    w = fshr(r * dth + (64'sd1 <<< (FRAC_BITS - 1)), FRAC_BITS);
    c.pos_x = fuse_sat(r, x, 0, 0);
    c.pos_y = fuse_sat(r, y, 0, 0);
    c.vel_x = fuse_sat(dr, x, -w, y);
    c.vel_y = fuse_sat(dr, y, w, x);
    return c;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver ready, driven at the falling edge
  always @(negedge clk) begin
    if (rst) states.ready <= 1'b0;
    else if (hold_off > 0) begin
      states.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else states.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cart_t want;
    if (!rst && states.valid && states.ready) begin
      states_seen++;
      if (cart_q.size() == 0) begin
        $error("transaction with no expectation");
        errors++;
      end else begin
        want = cart_q.pop_front();
        if (states.pos_x !== want.pos_x) begin
          $error("pos_x exp %h got %h", want.pos_x, states.pos_x); errors++;
        end
        if (states.pos_y !== want.pos_y) begin
          $error("pos_y exp %h got %h", want.pos_y, states.pos_y); errors++;
        end
        if (states.vel_x !== want.vel_x) begin
          $error("vel_x exp %h got %h", want.vel_x, states.vel_x); errors++;
        end
        if (states.vel_y !== want.vel_y) begin
          $error("vel_y exp %h got %h", want.vel_y, states.vel_y); errors++;
        end
      end
    end
  end

  // valid stays high after a transaction; the next call (when it idles) or the caller drops it
  task automatic send_row(row_t rw);
    while ($urandom_range(99) < send_idle_pct) begin
      rows.valid <= 1'b0;
      @(negedge clk);
    end
    rows.valid <= 1'b1;
    rows.radius <= rw.radius;
    rows.angle <= rw.angle;
    rows.radial_rate <= rw.radial_rate;
    rows.angular_rate <= rw.angular_rate;
    @(posedge clk);
    while (!rows.ready) @(posedge clk);
    cart_q.push_back(convert_row(rw));
    rows_sent++;
    @(negedge clk);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(5))
      0: return $urandom_range(1, 0) ? 32'h7FFFFFFF : 32'h80000000;
      1: return 32'(signed'($urandom_range(200000)) - 100000);
      2: return 32'(signed'($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    word_t v [6] = '{32'h7FFFFFFF, 32'h80000000, 0, 32'h00010000, 32'hFFFF0000, 32'h0003243F};
    for (int i = 0; i < 6; i++)
      send_row('{v[i], v[(i + 1) % 6], v[(i + 2) % 6], v[(i + 3) % 6]});
    send_row('{32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h7FFFFFFF});
    send_row('{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000});
    send_row('{32'h00010000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h00000001});
  endtask

  task automatic test_quadrants();
    // angles near each quarter turn boundary, both signs
    word_t a [8] = '{32'h00019220, 32'h0001921F, 32'h0003243F, 32'h00032440,
                     32'h0004B65F, 32'hFFFE6DE0, 32'hFFFCDBC1, 32'h0006487F};
    for (int i = 0; i < 8; i++) send_row('{32'h00050000, a[i], 32'h00020000, 32'hFFFF8000});
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_row('{rand_word(), rand_word(), rand_word(), rand_word()});
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rows.valid <= 1'b0;
    @(negedge clk);
    hold_off <= 300;
    repeat (80) send_row('{rand_word(), rand_word(), rand_word(), rand_word()});
  endtask

  initial begin
    rows.valid = 1'b0;
    rows.radius = '0;
    rows.angle = '0;
    rows.radial_rate = '0;
    rows.angular_rate = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_quadrants();
    test_random(340, 0, 0);
    test_random(340, 47, 0);
    test_random(340, 0, 47);
    test_random(300, 11, 11);
    test_backpressure();
    rows.valid <= 1'b0;
    recv_stall_pct = 20;
    while (cart_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Converted %0d rows (extremes, quadrant edges, random, long receiver stall);",
             rows_sent);
    $display("%0d results checked over %0d cycles, %0d field errors.",
             states_seen, cycles, errors);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

### sim.f
rtl/pcs_pkg.sv
rtl/pcs_if.sv
rtl/pcs_cordic.sv
rtl/polar_to_cartesian_state.sv
tb/pcs_tb_if.sv
tb/tb.sv
